>>> hw/rtl/ffua_pkg.sv
package ffua_pkg;

    // Default geometry of the managed area.
    localparam int DEF_UNITS_PER_PAGE = 16;
    localparam int DEF_UNIT_BYTES     = 256;
    localparam int DEF_PAGE_COUNT     = 4;

    // Fixed widths of the request and result fields.
    localparam int SIZE_W       = 16;
    localparam int PAGE_FIELD_W = 2;
    localparam int UNIT_FIELD_W = 4;

    // Request commands.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_SCAN,
        ST_FREE,
        ST_DONE
    } ffua_state_t;

    // Updates to the mark store issued by the sequencer.
    typedef struct packed {
        logic set_start;
        logic clr_start;
        logic set_end;
        logic clr_end;
    } mark_ctl_t;

    // One finished result.
    typedef struct packed {
        logic                    ok;
        logic [PAGE_FIELD_W-1:0] got_page;
        logic [UNIT_FIELD_W-1:0] got_unit;
    } result_t;

endpackage

>>> hw/rtl/first_fit_unit_allocator_unit.sv
// Channel  | Direction | Handshake           | Payload
// request  | in        | in_valid, in_stall  | cmd, size_bytes, page_index, unit_index
// result   | out       | out_valid, out_stall| ok, got_page, got_unit
//
// One request is handled at a time; in_stall stays high while it is being worked on.
// An allocate first checks the size (one unit size added per cycle, up to UNITS_PER_PAGE
// unit sizes), then scans first fit (one unit per cycle, no scan for a bad size, at most
// PAGE_COUNT * UNITS_PER_PAGE units), then hands the result over and goes back to idle;
// a free in range walks the units up to and including the end mark (at most UNITS_PER_PAGE),
// then hands the result over and goes back to idle.
// Reset clears all marks at once; a finished result waits in the output register
// while the next request is already taken in, and a stalled output holds the next one.
module first_fit_unit_allocator_unit #(
    parameter int UNITS_PER_PAGE = ffua_pkg::DEF_UNITS_PER_PAGE,
    parameter int UNIT_BYTES     = ffua_pkg::DEF_UNIT_BYTES,
    parameter int PAGE_COUNT     = ffua_pkg::DEF_PAGE_COUNT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [ffua_pkg::SIZE_W-1:0]       size_bytes,
    input  logic [ffua_pkg::PAGE_FIELD_W-1:0] page_index,
    input  logic [ffua_pkg::UNIT_FIELD_W-1:0] unit_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              ok,
    output logic [ffua_pkg::PAGE_FIELD_W-1:0] got_page,
    output logic [ffua_pkg::UNIT_FIELD_W-1:0] got_unit
);
    import ffua_pkg::*;

    localparam int UW = $clog2(UNITS_PER_PAGE);
    localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    mark_ctl_t   ctl;
    result_t     res;
    logic [PW-1:0] page;
    logic [UW-1:0] start_unit;
    logic [UW-1:0] cursor;
    logic          start_bit;
    logic          end_bit;
    logic          busy;
    logic          res_valid;
    logic          res_take;
    logic          in_take;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    ok_reg;
    logic [PAGE_FIELD_W-1:0] got_page_reg;
    logic [UNIT_FIELD_W-1:0] got_unit_reg;

    assign in_stall = busy;
    assign in_take  = in_valid && !busy;
    assign res_take = !out_valid_reg || !out_stall;

    ffua_seq #(
        .UNITS_PER_PAGE (UNITS_PER_PAGE),
        .UNIT_BYTES     (UNIT_BYTES),
        .PAGE_COUNT     (PAGE_COUNT)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_take    (in_take),
        .cmd        (cmd),
        .size_bytes (size_bytes),
        .page_index (page_index),
        .unit_index (unit_index),
        .start_bit  (start_bit),
        .end_bit    (end_bit),
        .ctl        (ctl),
        .page       (page),
        .start_unit (start_unit),
        .cursor     (cursor),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    ffua_marks #(
        .UNITS_PER_PAGE (UNITS_PER_PAGE),
        .PAGE_COUNT     (PAGE_COUNT)
    ) u_marks (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .page       (page),
        .start_unit (start_unit),
        .cursor     (cursor),
        .start_bit  (start_bit),
        .end_bit    (end_bit)
    );

    // The output register is loaded when empty or being emptied this cycle.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            ok_reg       <= res.ok;
            got_page_reg <= res.got_page;
            got_unit_reg <= res.got_unit;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign got_page  = got_page_reg;
    assign got_unit  = got_unit_reg;

endmodule

>>> hw/rtl/ffua_marks.sv
module ffua_marks #(
    parameter int UNITS_PER_PAGE = ffua_pkg::DEF_UNITS_PER_PAGE,
    parameter int PAGE_COUNT     = ffua_pkg::DEF_PAGE_COUNT,
    localparam int UW = $clog2(UNITS_PER_PAGE),
    localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffua_pkg::mark_ctl_t ctl,
    input  logic [PW-1:0]       page,
    input  logic [UW-1:0]       start_unit,
    input  logic [UW-1:0]       cursor,
    output logic                start_bit,
    output logic                end_bit
);
    import ffua_pkg::*;

    logic [UNITS_PER_PAGE-1:0] start_reg  [PAGE_COUNT];
    logic [UNITS_PER_PAGE-1:0] end_reg    [PAGE_COUNT];
    logic [UNITS_PER_PAGE-1:0] start_next [PAGE_COUNT];
    logic [UNITS_PER_PAGE-1:0] end_next   [PAGE_COUNT];

    // The marks of the current page at the cursor feed the scan and the free walk.
    assign start_bit = start_reg[page][cursor];
    assign end_bit   = end_reg[page][cursor];

    // A start mark is written at the run's first unit, an end mark at the cursor.
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        if (ctl.set_start)
        begin
            start_next[page][start_unit] = 1'b1;
        end
        if (ctl.clr_start)
        begin
            start_next[page][start_unit] = 1'b0;
        end
        if (ctl.set_end)
        begin
            end_next[page][cursor] = 1'b1;
        end
        if (ctl.clr_end)
        begin
            end_next[page][cursor] = 1'b0;
        end
    end

    // Every page starts with all units free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAGE_COUNT; p++)
            begin
                start_reg[p] <= '0;
                end_reg[p]   <= '0;
            end
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

endmodule

>>> hw/rtl/ffua_seq.sv
module ffua_seq #(
    parameter int UNITS_PER_PAGE = ffua_pkg::DEF_UNITS_PER_PAGE,
    parameter int UNIT_BYTES     = ffua_pkg::DEF_UNIT_BYTES,
    parameter int PAGE_COUNT     = ffua_pkg::DEF_PAGE_COUNT,
    localparam int UW = $clog2(UNITS_PER_PAGE),
    localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_take,
    input  logic                              cmd,
    input  logic [ffua_pkg::SIZE_W-1:0]       size_bytes,
    input  logic [ffua_pkg::PAGE_FIELD_W-1:0] page_index,
    input  logic [ffua_pkg::UNIT_FIELD_W-1:0] unit_index,
    input  logic                              start_bit,
    input  logic                              end_bit,
    output ffua_pkg::mark_ctl_t               ctl,
    output logic [PW-1:0]                     page,
    output logic [UW-1:0]                     start_unit,
    output logic [UW-1:0]                     cursor,
    output logic                              busy,
    output logic                              res_valid,
    output ffua_pkg::result_t                 res,
    input  logic                              res_take
);
    import ffua_pkg::*;

    localparam int NW = $clog2(UNITS_PER_PAGE + 1);
    localparam int DW = NW + 1;
    localparam int AW = $clog2(UNITS_PER_PAGE * UNIT_BYTES + 1);
    localparam int CW = (AW > SIZE_W) ? AW : SIZE_W;

    ffua_state_t       state_reg,  state_next;
    logic [SIZE_W-1:0] size_reg,   size_next;
    logic [AW-1:0]     acc_reg,    acc_next;
    logic [NW-1:0]     need_reg,   need_next;
    logic [NW-1:0]     len_reg,    len_next;
    logic [DW-1:0]     depth_reg,  depth_next;
    logic [PW-1:0]     page_reg,   page_next;
    logic [UW-1:0]     cursor_reg, cursor_next;
    logic [UW-1:0]     first_reg,  first_next;
    logic              ok_reg,     ok_next;

    // Step unit: depth, run length and run start for the unit at the cursor.
    logic [DW-1:0] depth_in;
    logic          unit_free;
    logic [NW-1:0] len_in;
    logic [UW-1:0] first_in;
    logic          last_unit;
    logic          last_page;
    logic          in_range;

    assign depth_in  = depth_reg + DW'(start_bit);
    assign unit_free = (depth_in == '0);
    assign len_in    = unit_free ? (len_reg + NW'(1)) : '0;
    assign first_in  = unit_free ? first_reg : (cursor_reg + UW'(1));
    assign last_unit = (cursor_reg == UW'(UNITS_PER_PAGE - 1));
    assign last_page = (page_reg == PW'(PAGE_COUNT - 1));
    assign in_range  = ({{(32 - PAGE_FIELD_W){1'b0}}, page_index} < 32'(PAGE_COUNT))
                    && ({{(32 - UNIT_FIELD_W){1'b0}}, unit_index} < 32'(UNITS_PER_PAGE));

    assign page       = page_reg;
    assign start_unit = first_reg;
    assign cursor     = cursor_reg;
    assign busy       = (state_reg != ST_IDLE);
    assign res.ok       = ok_reg;
    assign res.got_page = PAGE_FIELD_W'(page_reg);
    assign res.got_unit = UNIT_FIELD_W'(first_reg);

    // Next state and mark updates.
    always_comb
    begin
        state_next  = state_reg;
        size_next   = size_reg;
        acc_next    = acc_reg;
        need_next   = need_reg;
        len_next    = len_reg;
        depth_next  = depth_reg;
        page_next   = page_reg;
        cursor_next = cursor_reg;
        first_next  = first_reg;
        ok_next     = ok_reg;
        ctl         = '0;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (cmd == CMD_ALLOC)
                    begin
                        size_next  = size_bytes;
                        acc_next   = AW'(UNIT_BYTES);
                        need_next  = NW'(1);
                        state_next = ST_SIZE;
                    end
                    else
                    begin
                        ok_next = 1'b1;
                        if (in_range)
                        begin
                            page_next   = PW'(page_index);
                            cursor_next = UW'(unit_index);
                            first_next  = UW'(unit_index);
                            state_next  = ST_FREE;
                        end
                        else
                        begin
                            page_next  = '0;
                            first_next = '0;
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            // Step unit-size multiples (up to a page) until size is met or passed.
            ST_SIZE:
            begin
                if (CW'(acc_reg) == CW'(size_reg))
                begin
                    page_next   = '0;
                    cursor_next = '0;
                    first_next  = '0;
                    depth_next  = '0;
                    len_next    = '0;
                    state_next  = ST_SCAN;
                end
                else if ((CW'(acc_reg) > CW'(size_reg)) ||
                         (need_reg == NW'(UNITS_PER_PAGE)))
                begin
                    ok_next    = 1'b0;
                    page_next  = '0;
                    first_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    acc_next  = acc_reg + AW'(UNIT_BYTES);
                    need_next = need_reg + NW'(1);
                end
            end

            // First-fit scan, one unit per cycle, pages in ascending order.
            ST_SCAN:
            begin
                if (unit_free && (len_in == need_reg))
                begin
                    ctl.set_start = 1'b1;
                    ctl.set_end   = 1'b1;
                    ok_next       = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (last_unit)
                begin
                    cursor_next = '0;
                    first_next  = '0;
                    depth_next  = '0;
                    len_next    = '0;
                    if (last_page)
                    begin
                        ok_next    = 1'b0;
                        page_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        page_next = page_reg + PW'(1);
                    end
                end
                else
                begin
                    depth_next  = depth_in - DW'(end_bit);
                    len_next    = len_in;
                    first_next  = first_in;
                    cursor_next = cursor_reg + UW'(1);
                end
            end

            // Clear the start mark; walk to the next end mark, if any; clear it.
            ST_FREE:
            begin
                ctl.clr_start = 1'b1;
                if (end_bit || last_unit)
                begin
                    ctl.clr_end = end_bit;
                    page_next   = '0;
                    first_next  = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cursor_next = cursor_reg + UW'(1);
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        acc_reg    <= acc_next;
        need_reg   <= need_next;
        len_reg    <= len_next;
        depth_reg  <= depth_next;
        page_reg   <= page_next;
        cursor_reg <= cursor_next;
        first_reg  <= first_next;
        ok_reg     <= ok_next;
    end

endmodule

>>> dv/tb_first_fit_unit_allocator_unit.sv
`timescale 1ns / 100ps

module tb_first_fit_unit_allocator_unit;

    import ffua_pkg::*;

    localparam int UNITS      = DEF_UNITS_PER_PAGE;
    localparam int UNIT_SIZE  = DEF_UNIT_BYTES;
    localparam int PAGES      = DEF_PAGE_COUNT;
    localparam int TAIL_WAIT  = 400;
    localparam int DRAIN_WAIT = 5000;
    localparam int HOLD_LEN   = 600;

    typedef struct {
        logic [PAGE_FIELD_W-1:0] page;
        logic [UNIT_FIELD_W-1:0] unit;
    } block_ref_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    cmd;
    logic [SIZE_W-1:0]       size_bytes;
    logic [PAGE_FIELD_W-1:0] page_index;
    logic [UNIT_FIELD_W-1:0] unit_index;
    logic                    out_valid;
    logic                    out_stall;
    logic                    ok;
    logic [PAGE_FIELD_W-1:0] got_page;
    logic [UNIT_FIELD_W-1:0] got_unit;

    // Predicted mark store, one start bit and one end bit per unit.
    logic [UNITS-1:0] head_bits [PAGES];
    logic [UNITS-1:0] tail_bits [PAGES];

    result_t    pending_results [$];
    block_ref_t live_blocks [$];

    int error_count;
    int checked_count;
    int alloc_ok_count;
    int alloc_refused_count;
    int frees_sent;
    int gap_max;
    int burst_left;
    int hold_left;
    int stall_pct;

    first_fit_unit_allocator_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .size_bytes (size_bytes),
        .page_index (page_index),
        .unit_index (unit_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .got_page   (got_page),
        .got_unit   (got_unit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the result of one request and applies it to the predicted marks.
    function automatic result_t apply_to_marks(logic c, logic [SIZE_W-1:0] sz,
                                               logic [PAGE_FIELD_W-1:0] pg,
                                               logic [UNIT_FIELD_W-1:0] un);
        result_t r;
        int      need;
        int      depth;
        int      run_first;
        int      run_len;
        bit      cleared;
        r = '0;
        if (c == CMD_ALLOC)
        begin
            if (sz != 0 && (sz % UNIT_SIZE) == 0 && (sz / UNIT_SIZE) <= UNITS)
            begin
                need = sz / UNIT_SIZE;
                for (int p = 0; p < PAGES && !r.ok; p++)
                begin
                    depth = 0;
                    run_first = 0;
                    run_len = 0;
                    for (int u = 0; u < UNITS && !r.ok; u++)
                    begin
                        depth += head_bits[p][u] ? 1 : 0;
                        if (depth == 0)
                            run_len++;
                        else
                        begin
                            run_first = u + 1;
                            run_len = 0;
                        end
                        if (run_len == need)
                        begin
                            head_bits[p][run_first] = 1'b1;
                            tail_bits[p][u] = 1'b1;
                            r.ok = 1'b1;
                            r.got_page = p[PAGE_FIELD_W-1:0];
                            r.got_unit = run_first[UNIT_FIELD_W-1:0];
                        end
                        depth -= tail_bits[p][u] ? 1 : 0;
                    end
                end
            end
        end
        else
        begin
            // A free clears the start mark, then the nearest end mark at or after it.
            r.ok = 1'b1;
            cleared = 1'b0;
            head_bits[pg][un] = 1'b0;
            for (int v = un; v < UNITS && !cleared; v++)
            begin
                if (tail_bits[pg][v])
                begin
                    tail_bits[pg][v] = 1'b0;
                    cleared = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Offers one request, waits for it to be taken and queues its predicted result.
    task automatic send_request(input logic c, input logic [SIZE_W-1:0] sz,
                                input logic [PAGE_FIELD_W-1:0] pg,
                                input logic [UNIT_FIELD_W-1:0] un,
                                output result_t predicted);
        int gap;
        in_valid   <= 1'b1;
        cmd        <= c;
        size_bytes <= sz;
        page_index <= pg;
        unit_index <= un;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = apply_to_marks(c, sz, pg, un);
        pending_results.push_back(predicted);
        if (c == CMD_FREE)
            frees_sent++;
        else if (predicted.ok)
            alloc_ok_count++;
        else
            alloc_refused_count++;

        // The sender works in bursts; between bursts it drops valid for a random gap.
        if (gap_max > 0)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, gap_max);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Receiver stall pattern, with an occasional long hold-off.
    initial
    begin
        int rx_cycle;
        rx_cycle = 0;
        stall_pct = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle % 128 == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compares every accepted result with the oldest prediction.
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_results.size() == 0)
                    report_error($sformatf("unexpected result ok=%0b page=%0d unit=%0d",
                                           ok, got_page, got_unit));
                else
                begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (ok !== want.ok || got_page !== want.got_page
                        || got_unit !== want.got_unit)
                        report_error($sformatf(
                            "result mismatch: expected ok=%0b page=%0d unit=%0d, got ok=%0b page=%0d unit=%0d",
                            want.ok, want.got_page, want.got_unit, ok, got_page, got_unit));
                end
            end
        end
    end

    // Size checks: zero, odd sizes, sizes above a page, and the smallest and largest good sizes.
    task automatic test_size_checks();
        result_t r;
        send_request(CMD_ALLOC, 16'd0, 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'd1, 2'd3, 4'd15, r);
        send_request(CMD_ALLOC, 16'd255, 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'd257, 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'hFFFF, 2'd3, 4'd15, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE * (UNITS + 1)), 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'hFF00, 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE), 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE * UNITS), 2'd0, 4'd0, r);
    endtask

    // Fills every page, then runs out of room and reuses a freed block.
    task automatic test_page_fill();
        result_t r;
        send_request(CMD_ALLOC, 16'(UNIT_SIZE * UNITS), 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE * UNITS), 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE * (UNITS - 1)), 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE), 2'd0, 4'd0, r);
        send_request(CMD_FREE, 16'd0, 2'd0, 4'd0, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE), 2'd0, 4'd0, r);
    endtask

    // Frees of units that are not block starts, and frees with no end mark left.
    task automatic test_irregular_frees();
        result_t r;
        send_request(CMD_FREE, 16'hFFFF, 2'd1, 4'd5, r);
        send_request(CMD_FREE, 16'd0, 2'd1, 4'd15, r);
        send_request(CMD_FREE, 16'd0, 2'd1, 4'd0, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE * 2), 2'd3, 4'd0, r);
        send_request(CMD_FREE, 16'd0, 2'd3, 4'd3, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE * UNITS), 2'd0, 4'd0, r);
        send_request(CMD_FREE, 16'd0, 2'd3, 4'd0, r);
        send_request(CMD_ALLOC, 16'(UNIT_SIZE * UNITS), 2'd0, 4'd0, r);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_hold();
        result_t r;
        gap_max = 0;
        hold_left = HOLD_LEN;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 2 == 0)
                send_request(CMD_ALLOC, 16'(UNIT_SIZE * $urandom_range(1, 3)),
                             2'($urandom), 4'($urandom), r);
            else
                send_request(CMD_FREE, 16'($urandom), 2'($urandom), 4'($urandom), r);
        end
        while (hold_left > 0)
            @(posedge clk);
    endtask

    // Mostly allocations and frees of live blocks, with some noise and bad sizes.
    task automatic test_random_traffic(input int total);
        result_t    r;
        block_ref_t blk;
        int         roll;
        int         need;
        int         pick;
        for (int i = 0; i < total; i++)
        begin
            if (i % 250 == 0)
            begin
                case ((i / 250) % 3)
                    0:       gap_max = 0;
                    1:       gap_max = 4;
                    default: gap_max = 20;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                case ($urandom_range(0, 19))
                    0:              need = UNITS;
                    1, 2, 3, 4, 5:  need = $urandom_range(5, UNITS);
                    default:        need = $urandom_range(1, 4);
                endcase
                send_request(CMD_ALLOC, 16'(UNIT_SIZE * need), 2'($urandom),
                             4'($urandom), r);
                if (r.ok)
                begin
                    blk.page = r.got_page;
                    blk.unit = r.got_unit;
                    live_blocks.push_back(blk);
                end
            end
            else if (roll < 80 && live_blocks.size() > 0)
            begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                blk = live_blocks[pick];
                live_blocks.delete(pick);
                send_request(CMD_FREE, 16'($urandom), blk.page, blk.unit, r);
            end
            else if (roll < 90)
                send_request(CMD_FREE, 16'($urandom), 2'($urandom), 4'($urandom), r);
            else if (roll < 95)
                send_request(CMD_ALLOC, 16'($urandom_range(0, 255) << 8), 2'($urandom),
                             4'($urandom), r);
            else
                send_request(CMD_ALLOC, 16'($urandom), 2'($urandom), 4'($urandom), r);
        end
    endtask

    // Run limit, well above the slowest correct run.
    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int waited;
        error_count = 0;
        checked_count = 0;
        alloc_ok_count = 0;
        alloc_refused_count = 0;
        frees_sent = 0;
        gap_max = 6;
        burst_left = 0;
        hold_left = 0;
        for (int p = 0; p < PAGES; p++)
        begin
            head_bits[p] = '0;
            tail_bits[p] = '0;
        end
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        out_stall  <= 1'b0;
        cmd        <= CMD_ALLOC;
        size_bytes <= '0;
        page_index <= '0;
        unit_index <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_checks();
        test_page_fill();
        test_irregular_frees();
        test_output_hold();
        test_random_traffic(1700);

        // Let the last results come out, then watch for stray ones.
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("Requests sent: %0d allocations placed, %0d allocations refused, %0d frees.",
                 alloc_ok_count, alloc_refused_count, frees_sent);
        $display("Results checked: %0d, errors: %0d.", checked_count, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
